// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by lkv_ctrl; all sample on clock, off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, cond, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/core/lkv_pkg.sv =====
package lkv_pkg;

   // request kinds carried on req_tuser
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // capacity register
   localparam int            CAP_BITS  = 5;
   localparam logic [4:0]    CAP_RESET = 5'd16;

   // command broadcast to every cell of the recency chain
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_ROTATE,
      CMD_SHIFT
   } cmd_type;

endpackage

// ===== rtl/core/lkv_cell.sv =====
module lkv_cell #(
   parameter int POS        = 0,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lkv_pkg::cmd_type      cmd,
   input  logic [IDX_BITS-1:0]   shift_idx,
   input  logic [KEY_BITS-1:0]   nxt_key,
   input  logic [VALUE_BITS-1:0] nxt_value,
   input  logic                  nxt_valid,
   input  logic [KEY_BITS-1:0]   prv_key,
   input  logic [VALUE_BITS-1:0] prv_value,
   input  logic                  prv_valid,
   output logic [KEY_BITS-1:0]   key,
   output logic [VALUE_BITS-1:0] value,
   output logic                  valid
);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (cmd)
         lkv_pkg::CMD_ROTATE: begin
            key_in   = nxt_key;
            value_in = nxt_value;
            valid_in = nxt_valid;
         end
         lkv_pkg::CMD_SHIFT: begin
            // cells at or below the target slot take their lower neighbor
            if (shift_idx >= IDX_BITS'(POS)) begin
               key_in   = prv_key;
               value_in = prv_value;
               valid_in = prv_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/core/lkv_ctrl.sv =====
module lkv_ctrl #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4,
   parameter int CNT_BITS   = 5,
   parameter int REQ_BITS   = 96,
   parameter int RSP_BITS   = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_BITS-1:0]          req_tdata,
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_BITS-1:0]          rsp_tdata,
   output logic [1:0]                   rsp_tuser,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lkv_pkg::CAP_BITS-1:0] csr_data,
   input  logic [KEY_BITS-1:0]          head_key,
   input  logic [VALUE_BITS-1:0]        head_value,
   input  logic                         head_valid,
   output logic [KEY_BITS-1:0]          new_key,
   output logic [VALUE_BITS-1:0]        new_value,
   output lkv_pkg::cmd_type             cell_cmd,
   output logic [IDX_BITS-1:0]          shift_idx
);

`include "assert_macros.svh"

   localparam int CMP_BITS = (CNT_BITS > lkv_pkg::CAP_BITS) ? CNT_BITS : lkv_pkg::CAP_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   state_type                    state_ff, state_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [lkv_pkg::CAP_BITS-1:0] capacity_ff, capacity_in;

   logic [IDX_BITS-1:0]   step_ff, step_in;
   logic                  put_ff, put_in;
   logic [KEY_BITS-1:0]   req_key_ff, req_key_in;
   logic [VALUE_BITS-1:0] req_value_ff, req_value_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   found_idx_ff, found_idx_in;
   logic [VALUE_BITS-1:0] found_value_ff, found_value_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [KEY_BITS-1:0]   last_key_ff, last_key_in;
   logic [VALUE_BITS-1:0] last_value_ff, last_value_in;
   logic [RSP_BITS-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]            rsp_tuser_ff, rsp_tuser_in;

   logic                  rsp_free;
   logic                  match;
   logic                  scan_last;
   logic [CMP_BITS-1:0]   cap_lo, cap_eff;
   logic                  evict;
   logic                  hit;
   logic [CNT_BITS-1:0]   fill_m1;
   logic [VALUE_BITS-1:0] value_out;
   logic [KEY_BITS-1:0]   ev_key;
   logic [VALUE_BITS-1:0] ev_value;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign match      = head_valid && (head_key == req_key_ff);
   assign scan_last  = (step_ff == IDX_BITS'(ENTRIES - 1));

   // capacity 0 acts as 1, anything above the cell count as the cell count
   assign cap_lo  = (capacity_ff == '0) ? CMP_BITS'(1) : CMP_BITS'(capacity_ff);
   assign cap_eff = (cap_lo > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_lo;

   assign evict     = put_ff && !found_ff && (CMP_BITS'(fill_ff) >= cap_eff);
   assign hit       = !put_ff && found_ff;
   assign fill_m1   = fill_ff - CNT_BITS'(1);
   assign value_out = hit ? found_value_ff : '0;
   assign ev_key    = evict ? last_key_ff : '0;
   assign ev_value  = evict ? last_value_ff : '0;

   // on a shift, slot 0 receives the request key; a get hit carries its old value along
   assign new_key   = req_key_ff;
   assign new_value = hit ? found_value_ff : req_value_ff;

   assign shift_idx = found_ff ? found_idx_ff :
                      (evict ? fill_m1[IDX_BITS-1:0] : fill_ff[IDX_BITS-1:0]);

   always_comb begin
      if (state_ff == S_SCAN) begin
         cell_cmd = lkv_pkg::CMD_ROTATE;
      end else if (state_ff == S_UPDATE && rsp_free && (found_ff || put_ff)) begin
         cell_cmd = lkv_pkg::CMD_SHIFT;
      end else begin
         cell_cmd = lkv_pkg::CMD_HOLD;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      capacity_in    = capacity_ff;
      step_in        = step_ff;
      put_in         = put_ff;
      req_key_in     = req_key_ff;
      req_value_in   = req_value_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_value_in = found_value_ff;
      fill_in        = fill_ff;
      last_key_in    = last_key_ff;
      last_value_in  = last_value_ff;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;

      if (csr_valid) begin
         capacity_in = csr_data;
      end
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in     = S_SCAN;
               put_in       = (req_tuser == lkv_pkg::OP_PUT);
               req_key_in   = req_tdata[KEY_BITS-1:0];
               req_value_in = req_tdata[KEY_BITS +: VALUE_BITS];
               step_in      = '0;
               found_in     = 1'b0;
               fill_in      = '0;
            end
         end
         S_SCAN: begin
            // head holds the entry that sat at slot step_ff before the scan
            if (head_valid) begin
               fill_in       = fill_ff + CNT_BITS'(1);
               last_key_in   = head_key;
               last_value_in = head_value;
            end
            if (match && !found_ff) begin
               found_in       = 1'b1;
               found_idx_in   = step_ff;
               found_value_in = head_value;
            end
            step_in = step_ff + IDX_BITS'(1);
            if (scan_last) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (rsp_free) begin
               state_in      = S_IDLE;
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_BITS'({ev_value, ev_key, value_out});
               rsp_tuser_in  = {evict, hit};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         capacity_ff   <= lkv_pkg::CAP_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         capacity_ff   <= capacity_in;
      end
      step_ff        <= step_in;
      put_ff         <= put_in;
      req_key_ff     <= req_key_in;
      req_value_ff   <= req_value_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_value_ff <= found_value_in;
      fill_ff        <= fill_in;
      last_key_ff    <= last_key_in;
      last_value_ff  <= last_value_in;
      rsp_tdata_ff   <= rsp_tdata_in;
      rsp_tuser_ff   <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `ASSERT_NEXT(a_scan_ends, state_ff == S_SCAN && scan_last, state_ff == S_UPDATE, "scan did not end")
   `ASSERT_NEXT(a_rsp_posted, state_ff == S_UPDATE && rsp_free, state_ff == S_IDLE && rsp_tvalid_ff, "response not posted")
   `ASSERT_IMPLIES(a_hit_no_evict, rsp_tvalid_ff, !(rsp_tuser_ff[0] && rsp_tuser_ff[1]), "hit and eviction together")
   `ASSERT_IMPLIES(a_evict_nonempty, state_ff == S_UPDATE && evict, fill_ff != CNT_BITS'(0), "eviction from empty cache")

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Channel | Dir | Handshake             | Payload (low bit first)
// req     | in  | req_tvalid/req_tready | tuser: opcode; tdata: key, value_in
// rsp     | out | rsp_tvalid/rsp_tready | tuser: hit, evicted;
//         |     |                       | tdata: value_out, evicted_key, evicted_value
// csr     | in  | csr_valid/csr_ready   | csr_data: capacity (always ready)
//
// Each request is taken in the idle state, then the scan rotates the whole cell chain
// once past the head comparator, then the update state shifts the chain for the
// move-to-front and posts the response; the next request is taken only after that.
// Reset clears every valid bit and sets capacity to 16; no clearing pass.
// A stalled response holds the update cycle; the chain waits with it.
module lru_key_value_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32,
   localparam int REQ_BITS  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((KEY_BITS + 2 * VALUE_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_BITS-1:0]          req_tdata,   // key, value_in, zero pad
   input  logic                         req_tuser,   // opcode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_BITS-1:0]          rsp_tdata,   // value_out, evicted_key, evicted_value
   output logic [1:0]                   rsp_tuser,   // hit, evicted
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lkv_pkg::CAP_BITS-1:0] csr_data    // capacity
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   // Chain wiring: slot 0 is the most recent entry and also the scan head.
   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];
   logic                  cell_valid [ENTRIES];

   logic [KEY_BITS-1:0]   new_key;
   logic [VALUE_BITS-1:0] new_value;
   lkv_pkg::cmd_type      cell_cmd;
   logic [IDX_BITS-1:0]   shift_idx;

   lkv_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS),
      .REQ_BITS   (REQ_BITS),
      .RSP_BITS   (RSP_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .head_key   (cell_key[0]),
      .head_value (cell_value[0]),
      .head_valid (cell_valid[0]),
      .new_key    (new_key),
      .new_value  (new_value),
      .cell_cmd   (cell_cmd),
      .shift_idx  (shift_idx)
   );

   // Rotate moves every entry one slot toward the head (the head wraps to the
   // tail); shift moves slots up to shift_idx one slot away from the head and
   // loads the request entry into slot 0.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      localparam int NXT = (i + 1) % ENTRIES;

      logic [KEY_BITS-1:0]   prv_key;
      logic [VALUE_BITS-1:0] prv_value;
      logic                  prv_valid;

      if (i == 0) begin : g_head
         assign prv_key   = new_key;
         assign prv_value = new_value;
         assign prv_valid = 1'b1;
      end else begin : g_body
         assign prv_key   = cell_key[i-1];
         assign prv_value = cell_value[i-1];
         assign prv_valid = cell_valid[i-1];
      end

      lkv_cell #(
         .POS        (i),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cell_cmd),
         .shift_idx (shift_idx),
         .nxt_key   (cell_key[NXT]),
         .nxt_value (cell_value[NXT]),
         .nxt_valid (cell_valid[NXT]),
         .prv_key   (prv_key),
         .prv_value (prv_value),
         .prv_valid (prv_valid),
         .key       (cell_key[i]),
         .value     (cell_value[i]),
         .valid     (cell_valid[i])
      );
   end

endmodule

// ===== dv/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   localparam int ENTRIES    = 16;
   localparam int REQ_W      = 96;    // key[63:0], value_in[95:64]
   localparam int RSP_W      = 128;   // value_out, evicted_key, evicted_value

   // receiver stall styles
   typedef enum int {
      RX_STREAM,   // always ready
      RX_COIN,     // per-cycle coin flip
      RX_RUNS      // alternating runs of stall and ready
   } rx_style_type;

   // one response as the block should post it
   typedef struct packed {
      logic        hit;
      logic [31:0] value_out;
      logic        evicted;
      logic [63:0] evicted_key;
      logic [31:0] evicted_value;
   } lookup_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_W-1:0]             req_tdata = '0;    // key, value_in
   logic                         req_tuser = lkv_pkg::OP_GET; // opcode
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_W-1:0]             rsp_tdata;  // value_out, evicted_key, evicted_value
   logic [1:0]                   rsp_tuser;  // hit, evicted
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [lkv_pkg::CAP_BITS-1:0] csr_data = '0;     // capacity

   // shadow copy of the recency stack; slot 0 is most recent
   logic [63:0]                  shadow_keys [ENTRIES];
   logic [31:0]                  shadow_values [ENTRIES];
   bit                           shadow_valid [ENTRIES];
   logic [lkv_pkg::CAP_BITS-1:0] shadow_capacity = lkv_pkg::CAP_RESET;

   lookup_result_type   pending_responses [$];
   lookup_result_type   oldest_response;

   int error_count = 0;
   int get_count = 0;
   int hit_count = 0;
   int put_count = 0;
   int evict_count = 0;
   int capacity_writes = 0;

   // sender burst shaping
   bit gaps_on = 1'b1;
   int burst_left = 0;

   // receiver: long hold-off request handed over by the tests
   int           rsp_hold_request = 0;
   int           hold_left = 0;
   int           style_left = 0;
   int           run_left = 0;
   bit           run_stalled = 1'b0;
   rx_style_type rx_style = RX_STREAM;

   lru_key_value_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #15_000_000;
      $display("%0t: timeout, %0d responses still expected", $time, pending_responses.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow cache
   // ------------------------------------------------------------------

   // pull slot idx to the head; slots 0 to idx-1 slide one place away from the head
   function automatic void promote_entry(input int idx);
      logic [63:0] k;
      logic [31:0] v;
      k = shadow_keys[idx];
      v = shadow_values[idx];
      for (int i = idx; i > 0; i--) begin
         shadow_keys[i]   = shadow_keys[i-1];
         shadow_values[i] = shadow_values[i-1];
         shadow_valid[i]  = shadow_valid[i-1];
      end
      shadow_keys[0]   = k;
      shadow_values[0] = v;
      shadow_valid[0]  = 1'b1;
   endfunction

   // apply one request to the shadow stack and return the response it causes
   function automatic lookup_result_type cache_access(input logic op,
                                                      input logic [63:0] req_key,
                                                      input logic [31:0] req_value);
      lookup_result_type rsp;
      int fill;
      int slot;
      int limit;
      rsp  = '0;
      fill = 0;
      while (fill < ENTRIES && shadow_valid[fill])
         fill++;
      slot = -1;
      for (int i = 0; i < fill; i++)
         if (slot < 0 && shadow_keys[i] == req_key)
            slot = i;

      if (op == lkv_pkg::OP_GET) begin
         // eviction fields stay zero on a lookup
         if (slot >= 0) begin
            rsp.hit       = 1'b1;
            rsp.value_out = shadow_values[slot];
            promote_entry(slot);
         end
      end else if (slot >= 0) begin
         // key already cached: update in place and move to front, no eviction
         shadow_values[slot] = req_value;
         promote_entry(slot);
      end else begin
         // capacity 0 acts as 1, anything above the entry count as full size
         limit = (shadow_capacity == 0) ? 1 :
                 (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
         // at or above the limit: drop exactly one, the least recent valid entry
         if (fill >= limit && fill > 0) begin
            rsp.evicted       = 1'b1;
            rsp.evicted_key   = shadow_keys[fill-1];
            rsp.evicted_value = shadow_values[fill-1];
            shadow_valid[fill-1] = 1'b0;
            fill--;
         end
         shadow_keys[fill]   = req_key;
         shadow_values[fill] = req_value;
         shadow_valid[fill]  = 1'b1;
         promote_entry(fill);
      end
      return rsp;
   endfunction

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (actual !== expected) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response: expected none, actual tuser=%b tdata=%h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            oldest_response = pending_responses.pop_front();
            check_field("hit", oldest_response.hit, rsp_tuser[0]);
            check_field("evicted", oldest_response.evicted, rsp_tuser[1]);
            check_field("value_out", oldest_response.value_out, rsp_tdata[31:0]);
            check_field("evicted_key", oldest_response.evicted_key, rsp_tdata[95:32]);
            check_field("evicted_value", oldest_response.evicted_value, rsp_tdata[127:96]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side backpressure: random styles, plus the long hold-off
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (style_left == 0) begin
         rx_style   = rx_style_type'($urandom_range(RX_STREAM, RX_RUNS));
         style_left = $urandom_range(200, 600);
      end else begin
         style_left--;
      end

      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            RX_STREAM: begin
               rsp_tready <= 1'b1;
            end
            RX_COIN: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (run_left == 0) begin
                  run_stalled = ~run_stalled;
                  run_left    = run_stalled ? $urandom_range(1, 40) : $urandom_range(1, 20);
               end else begin
                  run_left--;
               end
               rsp_tready <= !run_stalled;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // offer one request, wait for the handshake, then predict its response
   task automatic send_request(input logic op, input logic [63:0] req_key,
                               input logic [31:0] req_value);
      lookup_result_type rsp;
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {req_value, req_key};
      do @(posedge clock); while (!req_tready);

      rsp = cache_access(op, req_key, req_value);
      pending_responses.push_back(rsp);
      if (op == lkv_pkg::OP_GET) begin
         get_count++;
         hit_count += rsp.hit;
      end else begin
         put_count++;
         evict_count += rsp.evicted;
      end

      // bursts of back-to-back requests separated by random gaps;
      // gaps shorter than one lookup land inside the chain rotation
      if (burst_left > 0) begin
         burst_left--;
      end else if (gaps_on) begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // nothing in flight: request line low and every response back
   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [lkv_pkg::CAP_BITS-1:0] cap);
      wait_for_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      shadow_capacity = cap;
      capacity_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // lookup on empty cache, extreme keys/values, update of a present key
   task automatic test_basic_ops();
      send_request(lkv_pkg::OP_GET, 64'h0, 32'hffff_ffff);   // miss on empty; value ignored
      send_request(lkv_pkg::OP_PUT, 64'h0, 32'h0);
      send_request(lkv_pkg::OP_PUT, '1, '1);
      send_request(lkv_pkg::OP_GET, 64'h0, 32'h5a5a_5a5a);   // hit with value 0
      send_request(lkv_pkg::OP_GET, '1, 32'h0);
      send_request(lkv_pkg::OP_PUT, '1, 32'h1234_5678);      // update, moves to front
      send_request(lkv_pkg::OP_GET, '1, 32'h0);
      send_request(lkv_pkg::OP_GET, 64'h1, 32'hffff_ffff);   // near key, miss
      send_request(lkv_pkg::OP_PUT, 64'h0, 32'h8000_0001);   // update of the other key
   endtask

   // out-of-range capacity values: 0 behaves as 1, above 16 behaves as 16
   task automatic test_capacity_clamp();
      write_capacity(5'd0);
      send_request(lkv_pkg::OP_PUT, 64'hdead_beef_0000_0001, 32'h1111_1111); // evicts LRU
      send_request(lkv_pkg::OP_PUT, 64'hdead_beef_0000_0002, 32'h2222_2222); // evicts again
      send_request(lkv_pkg::OP_GET, 64'hdead_beef_0000_0001, 32'h0);         // still cached: hit
      send_request(lkv_pkg::OP_PUT, 64'hdead_beef_0000_0002, 32'h3333_3333); // present
      write_capacity(5'd31);
      send_request(lkv_pkg::OP_PUT, 64'h8000_0000_0000_0000, 32'h7fff_ffff);
      send_request(lkv_pkg::OP_GET, 64'hdead_beef_0000_0002, 32'h0);
      write_capacity(5'd17);
      send_request(lkv_pkg::OP_PUT, 64'h0000_0000_ffff_ffff, 32'h0000_ffff);
      send_request(lkv_pkg::OP_GET, 64'h8000_0000_0000_0000, 32'h0);
      write_capacity(5'd1);
      send_request(lkv_pkg::OP_PUT, 64'h0123_4567_89ab_cdef, 32'hcafe_f00d);
      send_request(lkv_pkg::OP_GET, 64'h0123_4567_89ab_cdef, 32'h0);
   endtask

   // response side held off long enough that the request side must stall
   task automatic test_backpressure();
      write_capacity(lkv_pkg::CAP_RESET);
      gaps_on = 1'b0;
      rsp_hold_request = 400;
      for (int i = 0; i < 20; i++)
         send_request(1'($urandom_range(0, 1)), 64'(i % 6), $urandom);
      gaps_on = 1'b1;
   endtask

   // random mix over a small key pool so hits, updates and evictions recur
   task automatic test_random_phase(input logic [lkv_pkg::CAP_BITS-1:0] cap, input int count);
      logic [63:0] pool [24];
      int          pool_size;
      int          limit;
      logic [63:0] req_key;
      logic        op;
      write_capacity(cap);
      limit     = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
      pool_size = limit + $urandom_range(0, 6);
      if (pool_size > 24)
         pool_size = 24;
      for (int i = 0; i < pool_size; i++)
         pool[i] = {$urandom, $urandom};
      gaps_on = ($urandom_range(0, 3) != 0);

      for (int n = 0; n < count; n++) begin
         req_key = pool[$urandom_range(0, pool_size - 1)];
         case ($urandom_range(0, 19))
            0:       req_key = {$urandom, $urandom};                   // fresh key
            1:       req_key = req_key ^ (64'h1 << $urandom_range(0, 63)); // one bit off
            default: ;
         endcase
         op = 1'($urandom_range(0, 1));
         send_request(op, req_key, pick_value());
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      // full cache first, then shrink below the fill, then sweep the extremes
      test_random_phase(5'd16, 180);
      test_random_phase(5'd3, 170);
      test_random_phase(5'd1, 170);
      test_random_phase(5'd0, 150);
      test_random_phase(5'd31, 180);
      test_random_phase(5'd17, 160);
      test_random_phase(5'($urandom_range(2, 15)), 180);
      test_random_phase(5'($urandom_range(2, 15)), 180);
      test_random_phase(lkv_pkg::CAP_RESET, 180);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      int waited;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_keys[i]   = '0;
         shadow_values[i] = '0;
         shadow_valid[i]  = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_capacity_clamp();
      test_backpressure();
      test_random_traffic();

      // drain: every response back, then let the bench idle before the summary
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_responses.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (pending_responses.size() != 0) begin
         error_count += pending_responses.size();
         $display("%0t: %0d responses never arrived", $time, pending_responses.size());
      end

      $display("Covered %0d lookups (%0d hits) and %0d inserts/updates (%0d evictions)",
               get_count, hit_count, put_count, evict_count);
      $display("over %0d capacity writes, with one 400-cycle response hold-off", capacity_writes);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
